@@ hw/rtl/fcpu_pkg.sv @@
`timescale 1ns / 1ps
// Package for the follow camera position unit: constants, beat types, command
// and CSR codes, lane control struct and the saturation helper. No dependencies.
package fcpu_pkg;

   localparam int VIEW_WIDTH_DEF  = 1280;
   localparam int VIEW_HEIGHT_DEF = 720;
   localparam int DIV_W           = 40;      // widest dividend: |p| << 8
   localparam int ONE_Q20         = 1 << 20;
   localparam logic [15:0] DECAY_Q16 = 16'd58982;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_SNAP  = 3'd1,
      CMD_SHAKE = 3'd2,
      CMD_W2S   = 3'd3,
      CMD_S2W   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_ZOOM   = 3'd0,
      CSR_SPEED  = 3'd1,
      CSR_BEN    = 3'd2,
      CSR_MINX   = 3'd3,
      CSR_MINY   = 3'd4,
      CSR_MAXX   = 3'd5,
      CSR_MAXY   = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [15:0]        delta_time;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [15:0] random_x;
      logic signed [15:0] random_y;
      logic [23:0]        shake_strength;
      logic [15:0]        shake_length;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_x;
      logic signed [31:0] result_y;
      logic               shaking;
   } rsp_type;

   typedef struct packed {
      logic       load;     // start divider
      logic       ph1;
      logic       ph2;
      logic       ph3;
      logic       commit;
      logic [2:0] cmd;
      logic       snap;     // move straight to desired position
      logic       renew;    // new shake offset
      logic       clr;      // shake ended, offset to zero
   } ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)       return 32'sh7fffffff;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

endpackage

@@ hw/rtl/fcpu_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on fcpu_pkg for the dividend width.
module fcpu_div import fcpu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [15:0]      divisor,
   output logic [DIV_W-1:0] quot,
   output logic [15:0]      rem,
   output logic             done
);
   localparam int CW = $clog2(DIV_W);

   logic [DIV_W-1:0] qd_ff, qd_in;
   logic [15:0]      acc_ff, acc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [16:0]      sh;

   always_comb begin
      sh      = {acc_ff, qd_ff[DIV_W-1]};
      qd_in   = qd_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         qd_in   = dividend;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, divisor}) begin
            acc_in = 16'(sh - {1'b0, divisor});
            qd_in  = {qd_ff[DIV_W-2:0], 1'b1};
         end else begin
            acc_in = sh[15:0];
            qd_in  = {qd_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_W - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      qd_ff  <= qd_in;
      acc_ff <= acc_in;
   end

   assign quot = qd_ff;
   assign rem  = acc_ff;
   assign done = !busy_ff;
endmodule

@@ hw/rtl/fcpu_lane.sv @@
`timescale 1ns / 1ps
// One axis lane: view division, follow move, bounds clamp, shake offset
// and point transforms. Holds the camera and offset of its axis.
// Depends on fcpu_pkg and fcpu_div.
module fcpu_lane import fcpu_pkg::*; #(
   parameter int VIEW = VIEW_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   input  logic [15:0]        zoom,      // effective, never zero
   input  logic [20:0]        tfac,      // Q1.20, at most 1.0
   input  logic [23:0]        amp,
   input  logic               bounds_en,
   input  logic signed [31:0] lo,
   input  logic signed [31:0] hi,
   input  logic signed [31:0] tgt,
   input  logic signed [31:0] pt,
   input  logic signed [15:0] rnd,
   output logic signed [31:0] res,
   output logic               div_done
);
   logic [DIV_W-1:0] quot, dvd;
   logic [15:0]      rem;

   logic signed [31:0] cam_ff, off_ff, d_ff, s2w_ff, w2s_ff, mv_ff;
   logic [DIV_W:0]     fv_ff;
   logic signed [50:0] mulw_ff;
   logic signed [40:0] offp_ff;
   logic signed [54:0] prod_ff;

   logic signed [DIV_W:0] qmag, qs;
   logic signed [33:0]    diffw;
   logic signed [41:0]    fvs, maxc, mid;
   logic signed [31:0]    bnd, cam_new;
   logic [31:0]           pmag;

   assign pmag = pt[31] ? 32'(-pt) : 32'(pt);
   assign dvd  = (ctl.cmd == CMD_S2W) ? {pmag, 8'd0} : DIV_W'(VIEW) << 15;

   fcpu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.load),
      .dividend (dvd),
      .divisor  (zoom),
      .quot     (quot),
      .rem      (rem),
      .done     (div_done)
   );

   assign qmag  = signed'({1'b0, quot});
   assign qs    = pt[31] ? -qmag : qmag;
   assign diffw = 34'(pt) - 34'(cam_ff) - 34'(off_ff);

   // bounds clamp; fv is the full view over zoom
   always_comb begin
      fvs  = signed'({1'b0, fv_ff});
      maxc = 42'(hi) - fvs;
      mid  = (42'(lo) + 42'(hi) - fvs) >>> 1;
      if (maxc < 42'(lo))        bnd = sat32(64'(mid));
      else if (42'(mv_ff) > maxc) bnd = sat32(64'(maxc));
      else if (mv_ff < lo)       bnd = lo;
      else                       bnd = mv_ff;
      cam_new = bounds_en ? bnd : mv_ff;
   end

   always_comb begin
      unique case (ctl.cmd)
         CMD_TICK, CMD_SNAP: res = cam_new;
         CMD_W2S:            res = w2s_ff;
         CMD_S2W:            res = s2w_ff;
         default:            res = cam_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.ph1) begin
         d_ff    <= sat32(64'(tgt) - 64'(qmag));
         fv_ff   <= {quot, 1'b0} + (DIV_W+1)'({rem, 1'b0} >= {1'b0, zoom});
         s2w_ff  <= sat32(64'(qs) + 64'(cam_ff) + 64'(off_ff));
         mulw_ff <= 51'(diffw * signed'({1'b0, zoom}));
         offp_ff <= 41'(rnd * signed'({1'b0, amp}));
      end
      if (ctl.ph2) begin
         prod_ff <= 55'((33'(d_ff) - 33'(cam_ff)) * signed'({1'b0, tfac}));
         w2s_ff  <= sat32(64'(mulw_ff >>> 8));
      end
      if (ctl.ph3) begin
         mv_ff <= ctl.snap ? d_ff : sat32(64'(cam_ff) + 64'(prod_ff >>> 20));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff <= '0;
         off_ff <= '0;
      end else if (ctl.commit) begin
         if (ctl.cmd == CMD_TICK || ctl.cmd == CMD_SNAP) cam_ff <= cam_new;
         if (ctl.clr)        off_ff <= '0;
         else if (ctl.renew) off_ff <= 32'(offp_ff >>> 15);
      end
   end
endmodule

@@ hw/rtl/follow_camera_position_unit_core.sv @@
`timescale 1ns / 1ps
// Follow camera position unit, top level. An item passes from acceptance to
// the result register through a divider load, the divide state (40 quotient
// bits of the bit-serial zoom divider in each lane plus the done check),
// three arithmetic phases and a commit. One item is in flight at a time, so
// the next beat is taken only once the previous one has been committed;
// a stalled result holds the commit and keeps the input stalled. Synchronous
// reset clears camera, shake state and registers to their defaults.
module follow_camera_position_unit_core import fcpu_pkg::*; #(
   parameter int VIEW_WIDTH  = VIEW_WIDTH_DEF,
   parameter int VIEW_HEIGHT = VIEW_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_LOAD = 6'b000010,
      S_DIV  = 6'b000100,
      S_PH1  = 6'b001000,
      S_PH2  = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      ph3_ff;

   logic [15:0]        zoom_ff, speed_ff;
   logic               ben_ff;
   logic signed [31:0] minx_ff, miny_ff, maxx_ff, maxy_ff;
   logic [15:0]        rem_ff;
   logic [23:0]        amp_ff;
   req_type            item_ff;
   logic [20:0]        t_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic        done_x, done_y, out_free, commit, shaking_now, ends;
   logic [15:0] ez;
   logic [31:0] tprod;
   logic [39:0] amp_dec;
   ctl_type     ctl;
   logic signed [31:0] res_x, res_y;

   assign ez        = (zoom_ff == 16'd0) ? 16'd1 : zoom_ff;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == S_FIN) && !ph3_ff && out_free;
   assign tprod     = speed_ff * item_ff.delta_time;
   assign amp_dec   = amp_ff * DECAY_Q16;

   assign shaking_now = (item_ff.command == CMD_TICK) && (rem_ff != 16'd0);
   assign ends        = item_ff.delta_time >= rem_ff;

   always_comb begin
      ctl        = '0;
      ctl.load   = (state_ff == S_LOAD);
      ctl.ph1    = (state_ff == S_PH1);
      ctl.ph2    = (state_ff == S_PH2);
      ctl.ph3    = ph3_ff;
      ctl.commit = commit;
      ctl.cmd    = item_ff.command;
      ctl.snap   = (item_ff.command == CMD_SNAP) || (speed_ff == 16'd0);
      ctl.renew  = shaking_now && !ends;
      ctl.clr    = shaking_now && ends;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_LOAD;
         S_LOAD: state_in = S_DIV;
         S_DIV:  if (done_x && done_y) state_in = S_PH1;
         S_PH1:  state_in = S_PH2;
         S_PH2:  state_in = S_FIN;
         S_FIN:  if (commit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   fcpu_lane #(.VIEW(VIEW_WIDTH)) u_lane_x (
      .clock (clock), .reset (reset), .ctl (ctl), .zoom (ez), .tfac (t_ff),
      .amp (amp_ff), .bounds_en (ben_ff), .lo (minx_ff), .hi (maxx_ff),
      .tgt (item_ff.target_x), .pt (item_ff.point_x), .rnd (item_ff.random_x),
      .res (res_x), .div_done (done_x)
   );

   fcpu_lane #(.VIEW(VIEW_HEIGHT)) u_lane_y (
      .clock (clock), .reset (reset), .ctl (ctl), .zoom (ez), .tfac (t_ff),
      .amp (amp_ff), .bounds_en (ben_ff), .lo (miny_ff), .hi (maxy_ff),
      .tgt (item_ff.target_y), .pt (item_ff.point_y), .rnd (item_ff.random_y),
      .res (res_y), .div_done (done_y)
   );

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) item_ff <= req_data;
      if (state_ff == S_LOAD)
         t_ff <= (tprod > 32'(ONE_Q20)) ? 21'(ONE_Q20) : tprod[20:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph3_ff       <= 1'b0;
         zoom_ff      <= 16'd256;
         speed_ff     <= '0;
         ben_ff       <= 1'b0;
         minx_ff      <= '0;
         miny_ff      <= '0;
         maxx_ff      <= '0;
         maxy_ff      <= '0;
         rem_ff       <= '0;
         amp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff <= state_in;
         ph3_ff   <= (state_ff == S_PH2);
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ZOOM:  zoom_ff  <= csr_wdata[15:0];
               CSR_SPEED: speed_ff <= csr_wdata[15:0];
               CSR_BEN:   ben_ff   <= csr_wdata[0];
               CSR_MINX:  minx_ff  <= csr_wdata;
               CSR_MINY:  miny_ff  <= csr_wdata;
               CSR_MAXX:  maxx_ff  <= csr_wdata;
               CSR_MAXY:  maxy_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (commit) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (commit) begin
            rsp_ff.result_x <= res_x;
            rsp_ff.result_y <= res_y;
            if (item_ff.command == CMD_SHAKE) begin
               amp_ff <= item_ff.shake_strength;
               rem_ff <= item_ff.shake_length;
               rsp_ff.shaking <= (item_ff.shake_length != 16'd0);
            end else if (shaking_now) begin
               if (ends) begin
                  rem_ff         <= '0;
                  rsp_ff.shaking <= 1'b0;
               end else begin
                  rem_ff         <= rem_ff - item_ff.delta_time;
                  amp_ff         <= amp_dec[39:16];
                  rsp_ff.shaking <= 1'b1;
               end
            end else begin
               rsp_ff.shaking <= (rem_ff != 16'd0);
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the follow camera position unit: drives commands,
// predicts camera moves, shake and transforms, and checks every result beat.
// Depends on fcpu_pkg and follow_camera_position_unit_core.
module testbench;
   import fcpu_pkg::*;

   localparam int VW = VIEW_WIDTH_DEF;
   localparam int VH = VIEW_HEIGHT_DEF;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 2000000;

   class camera_scoreboard;
      longint cam_x, cam_y, off_x, off_y;
      longint min_x, min_y, max_x, max_y;
      int unsigned zoom, speed, bound_on, shake_timer, shake_amp;
      rsp_type expected_q[$];
      int mismatches;

      function new();
         zoom = 256; speed = 0; bound_on = 0;
         min_x = 0; min_y = 0; max_x = 0; max_y = 0;
         cam_x = 0; cam_y = 0; off_x = 0; off_y = 0;
         shake_timer = 0; shake_amp = 0; mismatches = 0;
      endfunction

      function longint sat(longint v);
         if (v > MAX32) return MAX32;
         if (v < MIN32) return MIN32;
         return v;
      endfunction

      function longint scale_zoom();
         return (zoom == 0) ? 1 : longint'(zoom);
      endfunction

      function longint clamp_axis(longint pos, longint lo, longint hi, longint span);
         longint top;
         top = hi - span;
         if (top < lo) return sat((lo + hi - span) >>> 1);
         if (pos > top) pos = top;
         if (pos < lo) pos = lo;
         return sat(pos);
      endfunction

      function void set_register(csr_idx_type idx, logic [31:0] v);
         case (idx)
            CSR_ZOOM:  zoom = v[15:0];
            CSR_SPEED: speed = v[15:0];
            CSR_BEN:   bound_on = v[0];
            CSR_MINX:  min_x = longint'($signed(v));
            CSR_MINY:  min_y = longint'($signed(v));
            CSR_MAXX:  max_x = longint'($signed(v));
            CSR_MAXY:  max_y = longint'($signed(v));
            default: ;
         endcase
      endfunction

      function void note_request(req_type r);
         longint z, dx, dy, t, px, py, res_x, res_y;
         rsp_type e;
         z = scale_zoom();
         px = longint'($signed(r.point_x));
         py = longint'($signed(r.point_y));
         res_x = cam_x; res_y = cam_y;
         if (r.command == CMD_TICK || r.command == CMD_SNAP) begin
            dx = sat(longint'($signed(r.target_x)) - longint'(VW) * 32768 / z);
            dy = sat(longint'($signed(r.target_y)) - longint'(VH) * 32768 / z);
            if (r.command == CMD_TICK && speed != 0) begin
               t = longint'(speed) * longint'(r.delta_time);
               if (t > ONE_Q20) t = ONE_Q20;
               cam_x = sat(cam_x + (((dx - cam_x) * t) >>> 20));
               cam_y = sat(cam_y + (((dy - cam_y) * t) >>> 20));
            end else begin
               cam_x = dx; cam_y = dy;
            end
            if (bound_on) begin
               cam_x = clamp_axis(cam_x, min_x, max_x, longint'(VW) * 65536 / z);
               cam_y = clamp_axis(cam_y, min_y, max_y, longint'(VH) * 65536 / z);
            end
            if (r.command == CMD_TICK && shake_timer > 0) begin
               if (r.delta_time >= shake_timer) begin
                  shake_timer = 0; off_x = 0; off_y = 0;
               end else begin
                  shake_timer -= r.delta_time;
                  off_x = (longint'($signed(r.random_x)) * longint'(shake_amp)) >>> 15;
                  off_y = (longint'($signed(r.random_y)) * longint'(shake_amp)) >>> 15;
                  shake_amp = int'((longint'(shake_amp) * longint'(DECAY_Q16)) >> 16);
               end
            end
            res_x = cam_x; res_y = cam_y;
         end else if (r.command == CMD_SHAKE) begin
            shake_amp = r.shake_strength;
            shake_timer = r.shake_length;
         end else if (r.command == CMD_W2S) begin
            res_x = sat(((px - cam_x - off_x) * z) >>> 8);
            res_y = sat(((py - cam_y - off_y) * z) >>> 8);
         end else if (r.command == CMD_S2W) begin
            res_x = sat(px * 256 / z + cam_x + off_x);
            res_y = sat(py * 256 / z + cam_y + off_y);
         end
         e.result_x = res_x[31:0];
         e.result_y = res_y[31:0];
         e.shaking = (shake_timer > 0);
         expected_q.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat x=%0d y=%0d",
                                           got.result_x, got.result_y);
            return;
         end
         e = expected_q.pop_front();
         if (got.result_x !== e.result_x || got.result_y !== e.result_y ||
             got.shaking !== e.shaking) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected x=%0d y=%0d shk=%0b, got x=%0d y=%0d shk=%0b",
                        e.result_x, e.result_y, e.shaking,
                        got.result_x, got.result_y, got.shaking);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   req_type req_data = '0;
   logic rsp_valid, rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   camera_scoreboard sb = new();
   int cycles = 0;
   bit hold_request = 0;
   bit stim_done = 0;

   follow_camera_position_unit_core DUT (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      if (!reset && req_valid && !req_stall) sb.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // result-side stall pattern, with one long hold-off on request
   initial begin
      int run;
      bit mode;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1;
            repeat (600) @(posedge clock);
            hold_request = 0;
         end
         mode = ($urandom_range(0, 2) == 0);
         run = $urandom_range(1, 60);
         repeat (run) begin
            @(posedge clock);
            rsp_stall <= mode ? ($urandom_range(0, 1) == 1) : 1'b0;
         end
      end
   end

   int burst_left = 0;

   task automatic send_beat(req_type r);
      int gap;
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_register(logic [2:0] idx, logic [31:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(csr_idx_type'(idx), v);
      csr_valid <= 0;
   endtask

   // wait for all results, then let any in-flight item drain
   task automatic drain();
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 4000) - 2000;
         3, 4: return ($urandom_range(0, 400000) - 200000) * 256;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_beat();
      req_type r;
      int k;
      r.delta_time = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 600));
      r.target_x = pick32();
      r.target_y = pick32();
      r.point_x = pick32();
      r.point_y = pick32();
      r.random_x = 16'($urandom);
      r.random_y = 16'($urandom);
      r.shake_strength = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 9000));
      r.shake_length = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
      k = $urandom_range(0, 99);
      if (k < 45)      r.command = CMD_TICK;
      else if (k < 55) r.command = CMD_SNAP;
      else if (k < 67) r.command = CMD_SHAKE;
      else if (k < 80) r.command = CMD_W2S;
      else if (k < 95) r.command = CMD_S2W;
      else             r.command = 3'($urandom_range(5, 7));
      return r;
   endfunction

   function automatic logic [31:0] pick_zoom();
      case ($urandom_range(0, 5))
         0: return 1;
         1: return 65535;
         2: return 256;
         3: return 0;
         default: return $urandom_range(64, 2048);
      endcase
   endfunction

   initial begin
      req_type r;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings first
      r = '0;
      r.command = CMD_TICK; r.target_x = 32'sh7fffffff; r.target_y = 32'sh80000000;
      send_beat(r);
      r.command = CMD_SNAP; r.target_x = 32'sh80000000; r.target_y = 32'sh7fffffff;
      send_beat(r);
      r.command = CMD_SHAKE; r.shake_strength = 24'hffffff; r.shake_length = 16'd1000;
      send_beat(r);
      r.command = CMD_TICK; r.delta_time = 0; r.random_x = 16'sh7fff; r.random_y = 16'sh8000;
      send_beat(r);
      r.delta_time = 16'd10; r.random_x = 16'sh8000; r.random_y = 16'sh7fff;
      send_beat(r);
      r.command = CMD_W2S; r.point_x = 32'sh7fffffff; r.point_y = 32'sh80000000;
      send_beat(r);
      r.command = CMD_S2W;
      send_beat(r);
      r.command = CMD_TICK; r.delta_time = 16'hffff;
      send_beat(r);
      for (int c = 5; c < 8; c++) begin
         r.command = 3'(c);
         send_beat(r);
      end
      drain();
      write_register(CSR_SPEED, 32'hffff);
      write_register(CSR_ZOOM, 32'd0);
      write_register(CSR_BEN, 32'd1);
      write_register(CSR_MINX, 32'h80000000);
      write_register(CSR_MINY, 32'h00010000);
      write_register(CSR_MAXX, 32'h7fffffff);
      write_register(CSR_MAXY, 32'h00000100);   // world smaller than view
      write_register(3'd7, 32'hdeadbeef);
      r = '0;
      r.command = CMD_TICK; r.delta_time = 16'd1; r.target_x = 32'sh7fffffff;
      send_beat(r);
      r.delta_time = 16'hffff; r.target_x = 32'sh80000000;
      send_beat(r);
      r.command = CMD_S2W; r.point_x = 32'sh7fffffff; r.point_y = 32'sh80000000;
      send_beat(r);
      r.command = CMD_W2S;
      send_beat(r);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_register(CSR_ZOOM, ph == 0 ? 32'd1 : ph == 1 ? 32'd65535 : pick_zoom());
         write_register(CSR_SPEED, ph == 2 ? 32'd0 : ph == 3 ? 32'hffff
                                   : 32'($urandom_range(0, 2000)));
         write_register(CSR_BEN, ph % 2);
         write_register(CSR_MINX, ph == 4 ? 32'h80000000 : 32'(-($urandom_range(0, 1 << 24))));
         write_register(CSR_MINY, ph == 4 ? 32'h80000000 : 32'(-($urandom_range(0, 1 << 24))));
         write_register(CSR_MAXX, ph == 4 ? 32'h7fffffff : 32'($urandom_range(0, 1 << 25)));
         write_register(CSR_MAXY, ph == 4 ? 32'h7fffffff : 32'($urandom_range(0, 1 << 18)));
         for (int i = 0; i < 215; i++) begin
            if (ph == 2 && i == 50) hold_request = 1;
            send_beat(random_beat());
         end
         drain();
      end
      stim_done = 1;
      if (sb.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

@@ files.f @@
hw/rtl/fcpu_pkg.sv
hw/rtl/fcpu_div.sv
hw/rtl/fcpu_lane.sv
hw/rtl/follow_camera_position_unit_core.sv
bench/testbench.sv
